// File: sv/des_pkg.sv
// des_pkg: shared types, permutation tables, s-boxes and helper functions for the des pipeline
`timescale 1ns / 1ps
`default_nettype none

package des_pkg;

  localparam int ROUND_COUNT = 16;
  localparam int LATENCY     = ROUND_COUNT + 1;

  typedef logic [47:0] rkey_t;

  typedef struct packed {
    logic        valid;
    logic        cmd;
    logic [31:0] l;
    logic [31:0] r;
  } des_stage_t;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } des_cmd_t;

  localparam logic [7:0] IP_TAB [64] = '{
    8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,
    8'd60, 8'd52, 8'd44, 8'd36, 8'd28, 8'd20, 8'd12, 8'd4,
    8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,
    8'd64, 8'd56, 8'd48, 8'd40, 8'd32, 8'd24, 8'd16, 8'd8,
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,
    8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
    8'd61, 8'd53, 8'd45, 8'd37, 8'd29, 8'd21, 8'd13, 8'd5,
    8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7
  };

  localparam logic [7:0] FP_TAB [64] = '{
    8'd40, 8'd8, 8'd48, 8'd16, 8'd56, 8'd24, 8'd64, 8'd32,
    8'd39, 8'd7, 8'd47, 8'd15, 8'd55, 8'd23, 8'd63, 8'd31,
    8'd38, 8'd6, 8'd46, 8'd14, 8'd54, 8'd22, 8'd62, 8'd30,
    8'd37, 8'd5, 8'd45, 8'd13, 8'd53, 8'd21, 8'd61, 8'd29,
    8'd36, 8'd4, 8'd44, 8'd12, 8'd52, 8'd20, 8'd60, 8'd28,
    8'd35, 8'd3, 8'd43, 8'd11, 8'd51, 8'd19, 8'd59, 8'd27,
    8'd34, 8'd2, 8'd42, 8'd10, 8'd50, 8'd18, 8'd58, 8'd26,
    8'd33, 8'd1, 8'd41, 8'd9,  8'd49, 8'd17, 8'd57, 8'd25
  };

  localparam logic [7:0] E_TAB [48] = '{
    8'd32, 8'd1,  8'd2,  8'd3,  8'd4,  8'd5,
    8'd4,  8'd5,  8'd6,  8'd7,  8'd8,  8'd9,
    8'd8,  8'd9,  8'd10, 8'd11, 8'd12, 8'd13,
    8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17,
    8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21,
    8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25,
    8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29,
    8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd1
  };

  localparam logic [7:0] P_TAB [32] = '{
    8'd16, 8'd7,  8'd20, 8'd21, 8'd29, 8'd12, 8'd28, 8'd17,
    8'd1,  8'd15, 8'd23, 8'd26, 8'd5,  8'd18, 8'd31, 8'd10,
    8'd2,  8'd8,  8'd24, 8'd14, 8'd32, 8'd27, 8'd3,  8'd9,
    8'd19, 8'd13, 8'd30, 8'd6,  8'd22, 8'd11, 8'd4,  8'd25
  };

  localparam logic [7:0] PC1_TAB [56] = '{
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,
    8'd1,  8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18,
    8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27,
    8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36,
    8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15,
    8'd7,  8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22,
    8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29,
    8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
  };

  localparam logic [7:0] PC2_TAB [48] = '{
    8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,
    8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
    8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,
    8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
    8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55,
    8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
    8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53,
    8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
  };

  localparam logic [1:0] ROT_TAB [16] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  localparam logic [3:0] SBOX_TAB [8][4][16] = '{
    '{'{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7},
      '{4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
        4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8},
      '{4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
        4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0},
      '{4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
        4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13}},
    '{'{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
        4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10},
      '{4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
        4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5},
      '{4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
        4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15},
      '{4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
        4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9}},
    '{'{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
        4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8},
      '{4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
        4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1},
      '{4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
        4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7},
      '{4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
        4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12}},
    '{'{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
        4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15},
      '{4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
        4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9},
      '{4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
        4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4},
      '{4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
        4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14}},
    '{'{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
        4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9},
      '{4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
        4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6},
      '{4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
        4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14},
      '{4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
        4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3}},
    '{'{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
        4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11},
      '{4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
        4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8},
      '{4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
        4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6},
      '{4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
        4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13}},
    '{'{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
        4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1},
      '{4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
        4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6},
      '{4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
        4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2},
      '{4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
        4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12}},
    '{'{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
        4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7},
      '{4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
        4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2},
      '{4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
        4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8},
      '{4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
        4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}}
  };

  function automatic logic [63:0] ip_f(input logic [63:0] v);
    logic [63:0] res;
    res = '0;
    for (int i = 0; i < 64; i++) begin
      res[6'(63 - i)] = v[6'(64 - int'(IP_TAB[i]))];
    end
    return res;
  endfunction

  function automatic logic [63:0] fp_f(input logic [63:0] v);
    logic [63:0] res;
    res = '0;
    for (int i = 0; i < 64; i++) begin
      res[6'(63 - i)] = v[6'(64 - int'(FP_TAB[i]))];
    end
    return res;
  endfunction

  function automatic logic [47:0] e_f(input logic [31:0] v);
    logic [47:0] res;
    res = '0;
    for (int i = 0; i < 48; i++) begin
      res[6'(47 - i)] = v[5'(32 - int'(E_TAB[i]))];
    end
    return res;
  endfunction

  function automatic logic [31:0] p_f(input logic [31:0] v);
    logic [31:0] res;
    res = '0;
    for (int i = 0; i < 32; i++) begin
      res[5'(31 - i)] = v[5'(32 - int'(P_TAB[i]))];
    end
    return res;
  endfunction

  function automatic logic [55:0] pc1_f(input logic [63:0] v);
    logic [55:0] res;
    res = '0;
    for (int i = 0; i < 56; i++) begin
      res[6'(55 - i)] = v[6'(64 - int'(PC1_TAB[i]))];
    end
    return res;
  endfunction

  function automatic logic [47:0] pc2_f(input logic [55:0] v);
    logic [47:0] res;
    res = '0;
    for (int i = 0; i < 48; i++) begin
      res[6'(47 - i)] = v[6'(56 - int'(PC2_TAB[i]))];
    end
    return res;
  endfunction

  function automatic int rot_cum(input int rnd);
    int acc;
    acc = 0;
    for (int i = 0; i <= rnd; i++) begin
      acc = acc + int'(ROT_TAB[i]);
    end
    return acc;
  endfunction

  function automatic logic [27:0] rotl28(input logic [27:0] x, input int n);
    return (x << n) | (x >> (28 - n));
  endfunction

  function automatic logic [31:0] feistel_f(input logic [31:0] r, input rkey_t k);
    logic [47:0] x;
    logic [5:0]  g;
    logic [31:0] s;
    x = e_f(r) ^ k;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      g = x[6'(47 - 6 * i) -: 6];
      s[5'(31 - 4 * i) -: 4] = SBOX_TAB[3'(i)][{g[5], g[0]}][g[4:1]];
    end
    return p_f(s);
  endfunction

endpackage

`default_nettype wire

// File: sv/des_key_sched.sv
// des_key_sched: forms the sixteen round keys from the cipher key by pc-1, rotations and pc-2
`timescale 1ns / 1ps
`default_nettype none

module des_key_sched
  import des_pkg::*;
(
  input  wire logic [63:0] cipher_key,
  output rkey_t            round_key [ROUND_COUNT]
);

  logic [55:0] cd;

  assign cd = pc1_f(cipher_key);

  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_key
    localparam int Shift = rot_cum(i);
    logic [27:0] c_rot;
    logic [27:0] d_rot;
    assign c_rot        = rotl28(cd[55:28], Shift);
    assign d_rot        = rotl28(cd[27:0], Shift);
    assign round_key[i] = pc2_f({c_rot, d_rot});
  end

endmodule

`default_nettype wire

// File: sv/des_round.sv
// des_round: one registered feistel round of the des pipeline
`timescale 1ns / 1ps
`default_nettype none

module des_round
  import des_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire des_stage_t stage_i,
  input  wire rkey_t      round_key,
  output des_stage_t      stage_o
);

  des_stage_t stage_r;
  des_stage_t stage_nxt;

  always_comb begin
    stage_nxt.valid = stage_i.valid;
    stage_nxt.cmd   = stage_i.cmd;
    stage_nxt.l     = stage_i.r;
    stage_nxt.r     = stage_i.l ^ feistel_f(stage_i.r, round_key);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.cmd <= stage_nxt.cmd;
    stage_r.l   <= stage_nxt.l;
    stage_r.r   <= stage_nxt.r;
  end

  assign stage_o = stage_r;

endmodule

`default_nettype wire

// File: sv/des_block_cipher.sv
// des_block_cipher: top level, des encrypt/decrypt pipeline with sixteen round stages
//
// usage
//   cfg channel: cfg_valid/cfg_ready carry the 64-bit key in cfg_cipher_key; cfg_ready is
//   always high. write the key only while no block is in flight.
//   input: a block is taken at each rising edge with start high and busy low.
//   in_command selects encrypt (0) or decrypt (1); in_data_block is the 64-bit block.
//   busy stays low, so one block per cycle is taken with no gaps needed.
//   output: out_valid strobes for one cycle with out_result_block; the receiver
//   cannot stall, and none is needed since nothing backs up.
//   path: a block taken at an edge is held in the input stage, then passes through
//   the sixteen round stages in order before it appears on out_result_block.
//   throughput: one block per cycle, set by one feistel round per register stage
//   (input stage holding ip, then sixteen round stages; fp is wiring at the output).
//   reset: rst_n low clears every stage valid bit and sets the key to zero;
//   blocks in flight are dropped.
`timescale 1ns / 1ps
`default_nettype none

module des_block_cipher
  import des_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic        in_command,
  input  wire logic [63:0] in_data_block,
  output      logic        out_valid,
  output      logic [63:0] out_result_block,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [63:0] cfg_cipher_key
);

  logic [63:0] key_r;
  logic [63:0] key_nxt;
  des_stage_t  in_r;
  des_stage_t  in_nxt;
  logic [63:0] ip_blk;
  rkey_t       round_key [ROUND_COUNT];
  des_stage_t  stage [ROUND_COUNT + 1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  assign key_nxt = (cfg_valid && cfg_ready) ? cfg_cipher_key : key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  assign ip_blk = ip_f(in_data_block);

  always_comb begin
    in_nxt.valid = start && !busy;
    in_nxt.cmd   = in_command;
    in_nxt.l     = ip_blk[63:32];
    in_nxt.r     = ip_blk[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r.valid <= 1'b0;
    end else begin
      in_r.valid <= in_nxt.valid;
    end
    in_r.cmd <= in_nxt.cmd;
    in_r.l   <= in_nxt.l;
    in_r.r   <= in_nxt.r;
  end

  assign stage[0] = in_r;

  des_key_sched u_key_sched (
    .cipher_key (key_r),
    .round_key  (round_key)
  );

  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
    rkey_t sel_key;
    assign sel_key = (stage[i].cmd == CMD_DECRYPT) ? round_key[ROUND_COUNT - 1 - i]
                                                   : round_key[i];
    des_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_i   (stage[i]),
      .round_key (sel_key),
      .stage_o   (stage[i + 1])
    );
  end

  // final swap then inverse initial permutation
  assign out_valid        = stage[ROUND_COUNT].valid;
  assign out_result_block = fp_f({stage[ROUND_COUNT].r, stage[ROUND_COUNT].l});

endmodule

`default_nettype wire

// File: sv/des_chk.sv
// des_chk: port-level checker for des_block_cipher, attached by bind
`timescale 1ns / 1ps
`default_nettype none

module des_chk
  import des_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic cfg_ready
);

  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted beat produced no result beat");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, LATENCY))
    else $error("result beat without matching accepted beat");

  a_reset_flushes: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && cfg_ready)
    else $error("pipeline refused a beat");

endmodule

bind des_block_cipher des_chk u_des_chk (.*);

`default_nettype wire
